// ===== sv/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, command codes and constants of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DefStackDepth = 16;

    // Command codes
    localparam logic [3:0] CmdPush  = 4'd0;
    localparam logic [3:0] CmdAdd   = 4'd1;
    localparam logic [3:0] CmdSub   = 4'd2;
    localparam logic [3:0] CmdMul   = 4'd3;
    localparam logic [3:0] CmdDiv   = 4'd4;
    localparam logic [3:0] CmdNeg   = 4'd5;
    localparam logic [3:0] CmdDup   = 4'd6;
    localparam logic [3:0] CmdSwap  = 4'd7;
    localparam logic [3:0] CmdPrint = 4'd8;
    localparam logic [3:0] CmdClear = 4'd9;
    localparam logic [3:0] CmdPall  = 4'd10;

    // Status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StFew  = 2'd1;
    localparam logic [1:0] StFull = 2'd2;
    localparam logic [1:0] StDivz = 2'd3;

    // Operation classes handed from front to back
    localparam logic [2:0] OpNone  = 3'd0;
    localparam logic [2:0] OpArith = 3'd1;
    localparam logic [2:0] OpStack = 3'd2;
    localparam logic [2:0] OpPall  = 3'd3;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               has_value;
        logic [1:0]         status;
        logic [4:0]         stack_depth;
        logic               last;
    } t_out_item;

    // Classified command in the front-to-back queue
    typedef struct packed {
        logic [3:0]  cmd;
        logic [2:0]  op;
        logic [31:0] value;
    } t_qitem;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647)       r = 32'h7FFF_FFFF;
        else if (v < -34'sd2147483648) r = 32'h8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rpn_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_front
// Accepts input transactions, classifies each command and queues it.
// ----------------------------------------------------------------------------
module rpn_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  rpn_pkg::t_in_item  i_item,
    output logic               o_q_valid,
    input  wire                i_q_ready,
    output rpn_pkg::t_qitem    o_q_item
);
    import rpn_pkg::*;

    localparam int QDepth = 2;

    t_qitem     r_mem [QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_qitem     w_cls;
    logic       w_push, w_pop;

    // Classification
    always_comb begin
        w_cls.cmd   = i_item.cmd;
        w_cls.value = i_item.push_value;
        unique case (i_item.cmd)
            CmdAdd, CmdSub, CmdMul, CmdDiv, CmdNeg: w_cls.op = OpArith;
            CmdPush, CmdDup, CmdSwap, CmdPrint, CmdClear: w_cls.op = OpStack;
            CmdPall: w_cls.op = OpPall;
            default: w_cls.op = OpNone;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_cls;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/rpn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_div
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module rpn_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import rpn_pkg::*;

    logic [47:0] r_q;      // dividend magnitude shifts into quotient
    logic [32:0] r_rem;
    logic [31:0] r_d;
    logic        r_neg, r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [32:0] w_trial;
    logic [47:0] w_an;
    logic signed [49:0] w_sq;

    assign w_an    = i_num[31] ? {16'd0, -i_num} << 16 : {16'd0, i_num} << 16;
    assign w_trial = {r_rem[31:0], r_q[47]} - {1'b0, r_d};
    assign w_sq    = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    assign o_done  = r_done;
    assign o_quot  = (w_sq > 50'sd2147483647) ? 32'h7FFF_FFFF :
                     (w_sq < -50'sd2147483648) ? 32'h8000_0000 : w_sq[31:0];

    // Restoring division loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_q    <= w_an;
                r_rem  <= 33'd0;
                r_d    <= i_den[31] ? -i_den : i_den;
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_q[47]};
                    r_q   <= {r_q[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/rpn_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_back
// Executes queued commands against the operand stack and emits results.
// ----------------------------------------------------------------------------
module rpn_back #(
    parameter int StackDepth = rpn_pkg::DefStackDepth
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    output logic              o_q_ready,
    input  rpn_pkg::t_qitem   i_q_item,
    output logic              o_valid,
    input  wire               i_ready,
    output rpn_pkg::t_out_item o_item
);
    import rpn_pkg::*;

    localparam int AW = $clog2(StackDepth);
    localparam int CW = $clog2(StackDepth + 1);

    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SRd   = 3'd1;
    localparam logic [2:0] SExec = 3'd2;
    localparam logic [2:0] SMul  = 3'd3;
    localparam logic [2:0] SDiv  = 3'd4;
    localparam logic [2:0] SWr   = 3'd5;
    localparam logic [2:0] SPall = 3'd6;
    localparam logic [2:0] SOut  = 3'd7;

    logic [31:0]   r_stk [StackDepth];
    logic [2:0]    r_st;
    logic [CW-1:0] r_n;
    t_qitem        r_cmd;
    logic [31:0]   r_a, r_b, r_rd;
    logic [AW-1:0] r_ra;
    logic          r_re;
    logic          r_we;
    logic [AW-1:0] r_wa;
    logic [31:0]   r_wd;
    logic          r_swap2;
    logic signed [63:0] r_prod;
    logic          r_ov;
    t_out_item     r_out;
    logic          r_pall_rd;
    logic          w_div_start, w_div_done;
    logic [31:0]   w_quot;
    logic [CW-1:0] w_top, w_sec;

    assign o_valid   = r_ov;
    assign o_item    = r_out;
    assign o_q_ready = (r_st == SIdle);
    assign w_top     = r_n - CW'(1);
    assign w_sec     = r_n - CW'(2);
    // launch the divider once both operands are held and the divide is legal
    assign w_div_start = (r_st == SWr) && (r_cmd.cmd == CmdDiv) &&
                         (r_n >= CW'(2)) && (r_b != 32'd0);

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Stack memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_we) r_stk[r_wa] <= r_wd;
        if (r_re) r_rd <= r_stk[r_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SIdle;
            r_n  <= '0;
            r_ov <= 1'b0;
            r_we <= 1'b0;
            r_re <= 1'b0;
            r_pall_rd <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_re <= 1'b0;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                SIdle: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_item;
                        r_swap2 <= 1'b0;
                        r_re    <= 1'b1;
                        r_ra    <= w_sec[AW-1:0];
                        r_st    <= SRd;
                    end
                end
                SRd: begin
                    // second-from-top arriving; request top
                    r_re <= 1'b1;
                    r_ra <= w_top[AW-1:0];
                    r_st <= SExec;
                end
                SExec: begin
                    if (!r_swap2) begin
                        r_a     <= r_rd;
                        r_swap2 <= 1'b1;
                    end else if (!r_ov) begin
                        r_b <= r_rd;
                        r_st <= SWr;
                    end
                end
                SWr: begin
                    r_out.out_value   <= '0;
                    r_out.has_value   <= 1'b0;
                    r_out.status      <= StOk;
                    r_out.stack_depth <= 5'(r_n);
                    r_out.last        <= 1'b1;
                    r_st <= SOut;
                    priority case (r_cmd.cmd)
                        CmdAdd, CmdSub, CmdMul, CmdDiv: begin
                            if (r_n < CW'(2)) begin
                                r_out.status <= StFew;
                            end else if (r_cmd.cmd == CmdDiv && r_b == 32'd0) begin
                                r_out.status <= StDivz;
                            end else if (r_cmd.cmd == CmdAdd) begin
                                r_wd <= sat32(34'(signed'(r_a)) + 34'(signed'(r_b)));
                                r_st <= SPall;
                            end else if (r_cmd.cmd == CmdSub) begin
                                r_wd <= sat32(34'(signed'(r_a)) - 34'(signed'(r_b)));
                                r_st <= SPall;
                            end else if (r_cmd.cmd == CmdMul) begin
                                r_prod <= signed'(r_a) * signed'(r_b);
                                r_st <= SMul;
                            end else begin
                                r_st <= SDiv;
                            end
                        end
                        CmdNeg: begin
                            if (r_n < CW'(1)) r_out.status <= StFew;
                            else begin
                                r_wd <= sat32(-34'(signed'(r_b)));
                                r_st <= SPall;
                            end
                        end
                        CmdPush: begin
                            if (r_n == CW'(StackDepth)) r_out.status <= StFull;
                            else begin
                                r_we <= 1'b1;
                                r_wa <= r_n[AW-1:0];
                                r_wd <= r_cmd.value;
                                r_n  <= r_n + CW'(1);
                                r_out.stack_depth <= 5'(r_n + CW'(1));
                            end
                        end
                        CmdDup: begin
                            if (r_n < CW'(1)) r_out.status <= StFew;
                            else if (r_n == CW'(StackDepth)) r_out.status <= StFull;
                            else begin
                                r_we <= 1'b1;
                                r_wa <= r_n[AW-1:0];
                                r_wd <= r_b;
                                r_n  <= r_n + CW'(1);
                                r_out.stack_depth <= 5'(r_n + CW'(1));
                            end
                        end
                        CmdSwap: begin
                            if (r_n < CW'(2)) r_out.status <= StFew;
                            else begin
                                r_we <= 1'b1;
                                r_wa <= w_top[AW-1:0];
                                r_wd <= r_a;
                                r_st <= SMul;
                            end
                        end
                        CmdPrint: begin
                            if (r_n < CW'(1)) r_out.status <= StFew;
                            else begin
                                r_out.out_value <= r_b;
                                r_out.has_value <= 1'b1;
                            end
                        end
                        CmdClear: begin
                            r_n <= '0;
                            r_out.stack_depth <= 5'd0;
                        end
                        CmdPall: begin
                            if (r_n < CW'(1)) r_out.status <= StFew;
                            else begin
                                r_out.out_value   <= r_b;
                                r_out.has_value   <= 1'b1;
                                r_out.stack_depth <= 5'(w_top);
                                r_out.last        <= (w_top == '0);
                                r_n  <= w_top;
                                r_st <= (w_top == '0) ? SOut : SPall;
                                r_pall_rd <= (w_top != '0);
                            end
                        end
                        default: ;
                    endcase
                end
                SMul: begin
                    if (r_cmd.cmd == CmdSwap) begin
                        // second half of swap
                        r_we <= 1'b1;
                        r_wa <= w_sec[AW-1:0];
                        r_wd <= r_b;
                        r_st <= SOut;
                    end else begin
                        // floor shift by 16, saturate when the upper bits are not sign
                        if (r_prod[63:47] != {17{r_prod[63]}})
                            r_wd <= r_prod[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        else
                            r_wd <= r_prod[47:16];
                        r_st <= SPall;
                    end
                end
                SDiv: begin
                    if (w_div_done) begin
                        r_wd <= w_quot;
                        r_st <= SPall;
                    end
                end
                SPall: begin
                    if (r_pall_rd) begin
                        // print all: emit current result, then fetch next entry
                        if (!r_ov) begin
                            r_ov      <= 1'b1;
                            r_pall_rd <= 1'b0;
                            r_re      <= 1'b1;
                            r_ra      <= w_top[AW-1:0];
                            r_st      <= SRd;
                            r_cmd.cmd <= CmdPall;
                            r_swap2   <= 1'b1;
                        end
                    end else begin
                        // arithmetic write-back to new top
                        r_we <= 1'b1;
                        r_wa <= (r_cmd.cmd == CmdNeg) ? w_top[AW-1:0] : w_sec[AW-1:0];
                        if (r_cmd.cmd != CmdNeg) begin
                            r_n <= w_top;
                            r_out.stack_depth <= 5'(w_top);
                        end
                        r_out.out_value <= r_wd;
                        r_out.has_value <= 1'b1;
                        r_st <= SOut;
                    end
                end
                SOut: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= SIdle;
                    end
                end
                default: r_st <= SIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator over a bounded stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
//  channel  | signals                         | payload
//  input    | i_valid / o_ready               | t_in_item  (cmd, push_value)
//  output   | o_valid / i_ready               | t_out_item (value, status, ...)
//
//  Divide uses a 48-step shift/subtract divider; print all reads and emits
//  the entries one at a time, from the top of the stack down.
//  A two-entry queue lets the front accept while the back is busy.
//  Synchronous active-low reset empties the stack and the queue.
//  Apart from waiting on the divider, the back stalls only on the output register while i_ready is low.
module rpn_stack_calculator #(
    parameter int StackDepth = rpn_pkg::DefStackDepth
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  rpn_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output rpn_pkg::t_out_item o_item
);
    import rpn_pkg::*;

    logic   w_qv, w_qr;
    t_qitem w_qi;

    rpn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_q_valid (w_qv),
        .i_q_ready (w_qr),
        .o_q_item  (w_qi)
    );

    rpn_back #(.StackDepth(StackDepth)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qv),
        .o_q_ready (w_qr),
        .i_q_item  (w_qi),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );
endmodule
`default_nettype wire

// ===== tb/rpn_stack_calculator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb
// Self-checking bench for the RPN calculator: commands are sent through the
// input handshake, a local stack model predicts every result, and each result
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb;
    import rpn_pkg::*;

    localparam int Depth = DefStackDepth;
    localparam int CycleLimit = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    rpn_stack_calculator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    // Model state
    logic [31:0] calc_stack [Depth];
    int          calc_count;
    t_out_item   pending_results [$];
    int          fail_count;
    int          cycle_count;
    bit          idle_on;        // random gaps enabled
    int          sink_hold;      // cycles the receiver must still hold off

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint sx(logic [31:0] u);
        return longint'(signed'(u));
    endfunction

    function automatic t_out_item make_result(logic [31:0] v, logic h, logic [1:0] st,
                                              logic l);
        t_out_item r;
        r.out_value   = h ? v : 32'd0;
        r.has_value   = h;
        r.status      = st;
        r.stack_depth = calc_count[4:0];
        r.last        = l;
        return r;
    endfunction

    // Predict results of one accepted command and update the model stack
    task automatic predict_calc(t_in_item it);
        longint a, b, p, q;
        logic [31:0] r;
        int n;
        n = calc_count;
        case (it.cmd)
            CmdAdd, CmdSub, CmdMul, CmdDiv: begin
                if (n < 2) begin
                    pending_results.push_back(make_result(0, 0, StFew, 1));
                end else begin
                    a = sx(calc_stack[n-2]);
                    b = sx(calc_stack[n-1]);
                    if (it.cmd == CmdDiv && b == 0) begin
                        pending_results.push_back(make_result(0, 0, StDivz, 1));
                    end else begin
                        if (it.cmd == CmdAdd) r = clamp32(a + b);
                        else if (it.cmd == CmdSub) r = clamp32(a - b);
                        else if (it.cmd == CmdMul) begin
                            p = a * b;
                            q = p >>> 16;   // floor
                            r = clamp32(q);
                        end else r = clamp32((a * 65536) / b);
                        calc_stack[n-2] = r;
                        calc_count = n - 1;
                        pending_results.push_back(make_result(r, 1, StOk, 1));
                    end
                end
            end
            CmdPush: begin
                if (n >= Depth) pending_results.push_back(make_result(0, 0, StFull, 1));
                else begin
                    calc_stack[n] = it.push_value;
                    calc_count = n + 1;
                    pending_results.push_back(make_result(0, 0, StOk, 1));
                end
            end
            CmdNeg: begin
                if (n < 1) pending_results.push_back(make_result(0, 0, StFew, 1));
                else begin
                    r = clamp32(-sx(calc_stack[n-1]));
                    calc_stack[n-1] = r;
                    pending_results.push_back(make_result(r, 1, StOk, 1));
                end
            end
            CmdDup: begin
                if (n < 1) pending_results.push_back(make_result(0, 0, StFew, 1));
                else if (n >= Depth) pending_results.push_back(make_result(0, 0, StFull, 1));
                else begin
                    calc_stack[n] = calc_stack[n-1];
                    calc_count = n + 1;
                    pending_results.push_back(make_result(0, 0, StOk, 1));
                end
            end
            CmdSwap: begin
                if (n < 2) pending_results.push_back(make_result(0, 0, StFew, 1));
                else begin
                    r = calc_stack[n-1];
                    calc_stack[n-1] = calc_stack[n-2];
                    calc_stack[n-2] = r;
                    pending_results.push_back(make_result(0, 0, StOk, 1));
                end
            end
            CmdPrint: begin
                if (n < 1) pending_results.push_back(make_result(0, 0, StFew, 1));
                else pending_results.push_back(make_result(calc_stack[n-1], 1, StOk, 1));
            end
            CmdClear: begin
                calc_count = 0;
                pending_results.push_back(make_result(0, 0, StOk, 1));
            end
            CmdPall: begin
                if (n < 1) pending_results.push_back(make_result(0, 0, StFew, 1));
                else begin
                    while (calc_count > 0) begin
                        calc_count--;
                        pending_results.push_back(make_result(calc_stack[calc_count], 1,
                                                              StOk, calc_count == 0));
                    end
                end
            end
            default: pending_results.push_back(make_result(0, 0, StOk, 1));
        endcase
    endtask

    // Send one command; prediction happens at the accepting edge.
    // Valid stays up after acceptance until the next command or idle cycle.
    task automatic send_cmd(logic [3:0] cmd, logic [31:0] val);
        t_in_item it;
        it.cmd = cmd;
        it.push_value = val;
        while (idle_on && $urandom_range(0, 99) < 32) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_calc(it);
        @(negedge clk);
    endtask

    // Receiver ready: random gaps, or a long hold-off when requested
    always @(negedge clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !(idle_on && $urandom_range(0, 99) < 32);
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_out_item exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_item);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_item.out_value !== exp_r.out_value)
                    $display("%0t: out_value exp %h got %h", $time, exp_r.out_value,
                             out_item.out_value);
                if (out_item.has_value !== exp_r.has_value)
                    $display("%0t: has_value exp %b got %b", $time, exp_r.has_value,
                             out_item.has_value);
                if (out_item.status !== exp_r.status)
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             out_item.status);
                if (out_item.stack_depth !== exp_r.stack_depth)
                    $display("%0t: stack_depth exp %0d got %0d", $time, exp_r.stack_depth,
                             out_item.stack_depth);
                if (out_item.last !== exp_r.last)
                    $display("%0t: last exp %b got %b", $time, exp_r.last, out_item.last);
                if (out_item !== exp_r) fail_count++;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'd0;
            3: return $urandom_range(0, 8) << 16;
            4: return $urandom_range(0, 1) ? 32'hFFFF_0000 - ($urandom_range(0, 8) << 16)
                                           : $urandom_range(0, 32'h3_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Directed: error cases, extremes and every command
    task automatic test_directed();
        send_cmd(CmdAdd, 0);            // too few operands
        send_cmd(CmdPall, 0);           // print all on empty stack
        send_cmd(CmdNeg, 0);
        send_cmd(CmdPrint, 0);
        send_cmd(CmdPush, 32'h7FFF_FFFF);
        send_cmd(CmdSwap, 0);           // one entry only
        send_cmd(CmdPush, 32'h7FFF_FFFF);
        send_cmd(CmdAdd, 0);            // saturates high
        send_cmd(CmdPush, 32'h8000_0000);
        send_cmd(CmdNeg, 0);            // most negative negated
        send_cmd(CmdPush, 32'h8000_0000);
        send_cmd(CmdSub, 0);
        send_cmd(CmdPush, 32'hFFFF_FFFF);
        send_cmd(CmdMul, 0);
        send_cmd(CmdPush, 0);
        send_cmd(CmdDiv, 0);            // divide by zero
        send_cmd(CmdPush, 32'h0000_0001);
        send_cmd(CmdDiv, 32'hFFFF_FFFF); // ignored push value
        send_cmd(CmdDup, 0);
        send_cmd(CmdSwap, 0);
        send_cmd(4'd11, 32'h1234_5678); // unused code
        send_cmd(4'd15, 0);
        send_cmd(CmdPall, 0);
        send_cmd(CmdClear, 0);
    endtask

    // Fill to the top, overflow on push and dup, then drain with print all
    task automatic test_full_stack();
        for (int i = 0; i < Depth; i++) send_cmd(CmdPush, rand_value());
        send_cmd(CmdPush, 32'h5555_AAAA);
        send_cmd(CmdDup, 0);
        send_cmd(CmdPall, 0);
    endtask

    // Receiver holds off while commands keep coming, so the block stalls
    task automatic test_back_pressure();
        sink_hold = 300;
        for (int i = 0; i < 10; i++) send_cmd(CmdPush, $urandom);
        send_cmd(CmdPall, 0);
        for (int i = 0; i < 6; i++) send_cmd(CmdPrint, 0);
    endtask

    // Random well-formed sequences with occasional noise
    task automatic test_random(int count);
        logic [3:0] c;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) idle_on = 1'b0;   // stretch with no idling
            if (i == count / 2 + 20) idle_on = 1'b1;
            if ($urandom_range(0, 9) == 0) c = 4'($urandom_range(0, 15));
            else if (calc_count < 2 && $urandom_range(0, 3) != 0) c = CmdPush;
            else c = 4'($urandom_range(0, 8));
            if ($urandom_range(0, 40) == 0) c = CmdPall;
            else if ($urandom_range(0, 60) == 0) c = CmdClear;
            send_cmd(c, rand_value());
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        fail_count = 0;
        cycle_count = 0;
        calc_count = 0;
        idle_on = 1'b1;
        sink_hold = 0;
        out_ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_stack();
        test_back_pressure();
        test_random(60);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/rpn_pkg.sv
sv/rpn_front.sv
sv/rpn_div.sv
sv/rpn_back.sv
sv/rpn_stack_calculator.sv
tb/rpn_stack_calculator_tb.sv
